// File: rtl/core/plb_pkg.sv
// Package for the positional list buffer: operation and status codes,
// the command word broadcast to the cell row, and shared sizes. No dependencies.
`default_nettype none

package plb_pkg;

  // Operation codes carried by a beat on the input channel.
  localparam logic [2:0] FN_INS_FRONT = 3'd0;
  localparam logic [2:0] FN_INS_BACK  = 3'd1;
  localparam logic [2:0] FN_INS_AT    = 3'd2;
  localparam logic [2:0] FN_DEL_FRONT = 3'd3;
  localparam logic [2:0] FN_DEL_BACK  = 3'd4;
  localparam logic [2:0] FN_DEL_AT    = 3'd5;
  localparam logic [2:0] FN_DUMP      = 3'd6;

  // Result status codes.
  localparam logic [1:0] STS_DONE    = 2'd0;
  localparam logic [1:0] STS_IGNORED = 2'd1;
  localparam logic [1:0] STS_FULL    = 2'd2;

  // Fixed widths of the channel fields.
  localparam int FUNC_W  = 3;
  localparam int VALUE_W = 8;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 6;

  // Wide enough to index any legal row length (up to 64 cells).
  localparam int CELL_IDX_W = 6;

  localparam int DEPTH_DEF      = 32;
  localparam int DATA_WIDTH_DEF = 8;

  typedef enum logic [1:0] {
    CM_HOLD = 2'd0,
    CM_INS  = 2'd1,
    CM_DEL  = 2'd2,
    CM_ROT  = 2'd3
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t             mode;
    logic [CELL_IDX_W-1:0]  idx;
  } cell_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/plb_cell.sv
// One storage cell of the positional list buffer row.
// Depends on plb_pkg for the broadcast command word.
`default_nettype none

module plb_cell
  import plb_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int IDX        = 0
) (
  input  wire logic                  clk,
  input  wire cell_cmd_t             cmd,
  input  wire logic [DATA_WIDTH-1:0] fill_data,
  input  wire logic [DATA_WIDTH-1:0] left_data,
  input  wire logic [DATA_WIDTH-1:0] right_data,
  output logic      [DATA_WIDTH-1:0] data
);

  localparam logic [CELL_IDX_W-1:0] MY_IDX = CELL_IDX_W'(IDX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  // Insert opens a gap at idx, delete closes the gap at idx, rotate moves
  // every live cell one step toward the front and wraps the front to idx.
  always_comb begin
    data_nxt = data_r;
    case (cmd.mode)
      CM_INS: begin
        if (MY_IDX > cmd.idx) begin
          data_nxt = left_data;
        end else if (MY_IDX == cmd.idx) begin
          data_nxt = fill_data;
        end
      end
      CM_DEL: begin
        if (MY_IDX >= cmd.idx) begin
          data_nxt = right_data;
        end
      end
      CM_ROT: begin
        if (MY_IDX < cmd.idx) begin
          data_nxt = right_data;
        end else if (MY_IDX == cmd.idx) begin
          data_nxt = fill_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

`default_nettype wire

// File: rtl/core/positional_list_buffer.sv
// Top level of the positional list buffer: operation decode, dump sequencer,
// output register and the row of plb_cell instances. Depends on plb_pkg, plb_cell.
//
// Usage: an ordered list of up to DEPTH elements of DATA_WIDTH bits is kept
// in a row of cells, front in cell 0. Each input beat (in_func, in_value,
// in_position) is one operation: insert front/back/at, delete front/back/at,
// or dump. Both channels use valid/stall; a beat moves at a rising edge with
// valid high and stall low.
// Timing: an insert or delete updates the row in the accepting cycle and its
// single result beat is valid on the next cycle. A dump of N elements first
// moves to the dump state, then emits one element beat per cycle while the
// receiver does not stall, the front of the row each time, while the row rotates
// by one cell; after N beats the row is back in its original order. The input
// stays stalled until the last dump beat is loaded; an empty dump gives one beat,
// like any other operation.
// Throughput: one insert or delete per cycle. The output register frees the
// input side: a new beat is taken while a result is shown, as long as the
// receiver takes that result in the same cycle.
// Reset (rst_n low, synchronous) empties the list, drops any pending result and
// holds in_stall high; cell contents are not cleared, since only live cells are read.
// When the receiver stalls, the result held stays unchanged, and in_stall
// stays high until there is room for the next result.
`default_nettype none

module positional_list_buffer
  import plb_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [FUNC_W-1:0]  in_func,
  input  wire logic [VALUE_W-1:0] in_value,
  input  wire logic [POS_W-1:0]   in_position,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_status,
  output logic [VALUE_W-1:0]      out_element,
  output logic                    out_element_valid,
  output logic                    out_last,
  output logic [COUNT_W-1:0]      out_count
);

  localparam int LENW = $clog2(DEPTH + 1);
  localparam int IDXW = $clog2(DEPTH);
  localparam int CW   = ((LENW > POS_W) ? LENW : POS_W) + 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [LENW-1:0]   len_r, len_nxt;
  logic [LENW-1:0]   rem_r, rem_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, status_nxt;
  logic [VALUE_W-1:0] out_element_r, element_nxt;
  logic              out_element_valid_r, evalid_nxt;
  logic              out_last_r, last_nxt;
  logic [COUNT_W-1:0] out_count_r;

  logic              out_free;
  logic              accept;
  logic              load_out;
  logic              full;
  logic [CW-1:0]     len_ext;
  logic [CW-1:0]     pos_ext;
  logic [CW-1:0]     pos_m1;
  logic [IDXW-1:0]   cmd_idx;
  cell_cmd_t         cmd;
  logic [DATA_WIDTH-1:0] fill_data;
  logic [DATA_WIDTH-1:0] value_dw;
  logic [VALUE_W-1:0]    front_elem;
  logic [COUNT_W-1:0]    count_nxt;
  logic [DATA_WIDTH-1:0] slot_q [DEPTH];

  // Width adaptation between the fixed channel fields and the parameters.
  for (genvar b = 0; b < DATA_WIDTH; b++) begin : g_val
    if (b < VALUE_W) begin : g_in
      assign value_dw[b] = in_value[b];
    end else begin : g_pad
      assign value_dw[b] = 1'b0;
    end
  end

  for (genvar b = 0; b < VALUE_W; b++) begin : g_elem
    if (b < DATA_WIDTH) begin : g_in
      assign front_elem[b] = slot_q[0][b];
    end else begin : g_pad
      assign front_elem[b] = 1'b0;
    end
  end

  for (genvar b = 0; b < COUNT_W; b++) begin : g_cnt
    if (b < LENW) begin : g_in
      assign count_nxt[b] = len_nxt[b];
    end else begin : g_pad
      assign count_nxt[b] = 1'b0;
    end
  end

  // The cell row. Neighbors at the ends are tied back to the cell itself;
  // cell 0 never selects its left input, and a delete reloads the last cell from itself.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cells
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;
    if (g == 0) begin : g_l0
      assign left_d = slot_q[g];
    end else begin : g_ln
      assign left_d = slot_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_rl
      assign right_d = slot_q[g];
    end else begin : g_rn
      assign right_d = slot_q[g+1];
    end
    plb_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX        (g)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .fill_data  (fill_data),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (slot_q[g])
    );
  end

  // Nothing is taken while reset is held.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !rst_n || !((state_r == ST_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;
  assign full     = (len_r == LENW'(DEPTH));
  assign len_ext  = CW'(len_r);
  assign pos_ext  = CW'(in_position);
  assign pos_m1   = pos_ext - CW'(1);

  // Decode of the accepted operation and the dump sequencer. Every path
  // that produces a result sets load_out; the row moves in the same cycle.
  always_comb begin
    state_nxt   = state_r;
    len_nxt     = len_r;
    rem_nxt     = rem_r;
    load_out    = 1'b0;
    status_nxt  = STS_DONE;
    element_nxt = '0;
    evalid_nxt  = 1'b0;
    last_nxt    = 1'b1;
    cmd.mode    = CM_HOLD;
    cmd_idx     = '0;
    fill_data   = value_dw;

    if (state_r == ST_DUMP) begin
      if (out_free) begin
        load_out    = 1'b1;
        element_nxt = front_elem;
        evalid_nxt  = 1'b1;
        last_nxt    = (rem_r == LENW'(1));
        cmd.mode    = CM_ROT;
        cmd_idx     = IDXW'(len_r - LENW'(1));
        fill_data   = slot_q[0];
        rem_nxt     = rem_r - LENW'(1);
        if (rem_r == LENW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
    end else if (accept) begin
      load_out = 1'b1;
      unique case (in_func) inside
        FN_INS_FRONT, FN_INS_BACK: begin
          if (full) begin
            status_nxt = STS_FULL;
          end else begin
            cmd.mode = CM_INS;
            cmd_idx  = (in_func == FN_INS_FRONT) ? '0 : IDXW'(len_r);
            len_nxt  = len_r + LENW'(1);
          end
        end
        FN_INS_AT: begin
          if (pos_ext == '0 || pos_ext > len_ext + CW'(1)) begin
            status_nxt = STS_IGNORED;
          end else if (full) begin
            status_nxt = STS_FULL;
          end else begin
            cmd.mode = CM_INS;
            cmd_idx  = pos_m1[IDXW-1:0];
            len_nxt  = len_r + LENW'(1);
          end
        end
        FN_DEL_FRONT, FN_DEL_BACK: begin
          if (len_r == '0) begin
            status_nxt = STS_IGNORED;
          end else begin
            cmd.mode = CM_DEL;
            cmd_idx  = (in_func == FN_DEL_FRONT) ? '0 : IDXW'(len_r - LENW'(1));
            len_nxt  = len_r - LENW'(1);
          end
        end
        FN_DEL_AT: begin
          if (pos_ext == '0 || pos_ext > len_ext) begin
            status_nxt = STS_IGNORED;
          end else begin
            cmd.mode = CM_DEL;
            cmd_idx  = pos_m1[IDXW-1:0];
            len_nxt  = len_r - LENW'(1);
          end
        end
        FN_DUMP: begin
          // An empty dump answers at once; otherwise the sequencer takes over.
          if (len_r != '0) begin
            load_out  = 1'b0;
            rem_nxt   = len_r;
            state_nxt = ST_DUMP;
          end
        end
        default: status_nxt = STS_IGNORED;
      endcase
    end
    cmd.idx = CELL_IDX_W'(cmd_idx);
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r        <= status_nxt;
      out_element_r       <= element_nxt;
      out_element_valid_r <= evalid_nxt;
      out_last_r          <= last_nxt;
      out_count_r         <= count_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_element       = out_element_r;
  assign out_element_valid = out_element_valid_r;
  assign out_last          = out_last_r;
  assign out_count         = out_count_r;

  // The list never grows past the row.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LENW'(DEPTH))
    else $error("list length exceeds the cell row");

  // During a dump the remaining count is live and within the length.
  a_dump_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DUMP) |-> (rem_r != '0 && rem_r <= len_r))
    else $error("dump remaining count out of range");

  // A dump never changes the length.
  a_dump_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DUMP) |=> (len_r == $past(len_r)))
    else $error("length changed during a dump");

  // One operation moves the length by at most one element.
  a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (len_r == $past(len_r) || len_r == $past(len_r) + LENW'(1) ||
                len_r == $past(len_r) - LENW'(1)))
    else $error("length moved by more than one element");

  // The last dump beat returns the sequencer to idle.
  a_dump_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DUMP && load_out && rem_r == LENW'(1))
      |=> (state_r == ST_IDLE && out_valid_r && out_last_r))
    else $error("dump did not finish on its last beat");

endmodule

`default_nettype wire
